### rtl/assert_macros.svh
// Assertion macros shared by the cursor text buffer RTL.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor text buffer check failed");

// The consequent must hold in the cycle after the antecedent.
`define CTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor text buffer check failed");

`endif

### rtl/ctb_pkg.sv
// Shared types and constants for the cursor text buffer.
// No dependencies; every other file in this block but assert_macros.svh imports it.
package ctb_pkg;

    // Default capacity of the text in bytes.
    localparam int DEPTH_DEFAULT = 256;

    // Command codes.
    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_FORWARD  = 3'd2,
        CMD_BACKWARD = 3'd3,
        CMD_START    = 3'd4,
        CMD_END      = 3'd5
    } cmd_t;

    // Status codes.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_TO_START,
        S_TO_END
    } state_t;

    // Per-cycle operation on a stack of cells.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } stack_op_t;

    // Control word for one stack.
    typedef struct packed {
        stack_op_t  op;
        logic [7:0] din;
    } stack_ctl_t;

    // Command word.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_in;
    } in_word_t;

    // Response word.
    typedef struct packed {
        logic [8:0] cursor_pos;
        logic [8:0] text_length;
        logic [7:0] char_before;
        logic [7:0] char_after;
        logic [1:0] status;
    } out_word_t;

endpackage

### rtl/ctb_cell.sv
// One byte cell of a stack chain: pushes from the cell above, pops from below.
// Depends on ctb_pkg.
module ctb_cell (
    input  logic                clk,
    input  ctb_pkg::stack_op_t  op,
    input  logic [7:0]          push_in,
    input  logic [7:0]          pop_in,
    output logic [7:0]          data
);
    import ctb_pkg::*;

    logic [7:0] data_reg;

    // Take the byte from the neighbor that the operation selects.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_PUSH: data_reg <= push_in;
            OP_POP:  data_reg <= pop_in;
            default: data_reg <= data_reg;
        endcase
    end

    assign data = data_reg;

endmodule

### rtl/ctb_stack.sv
// A stack built as a chain of DEPTH byte cells; cell 0 is the top.
// Depends on ctb_pkg and ctb_cell.
module ctb_stack #(
    parameter int DEPTH = ctb_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  ctb_pkg::stack_ctl_t ctl,
    output logic [7:0]          top,
    output logic [7:0]          second
);
    import ctb_pkg::*;

    logic [7:0] cell_data [DEPTH];

    // Each cell sees its upper neighbor on push and its lower neighbor on pop.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] push_src;
        logic [7:0] pop_src;

        if (i == 0)
        begin : g_first
            assign push_src = ctl.din;
        end
        else
        begin : g_rest
            assign push_src = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign pop_src = cell_data[i];
        end
        else
        begin : g_inner
            assign pop_src = cell_data[i+1];
        end

        ctb_cell u_cell (
            .clk     (clk),
            .op      (ctl.op),
            .push_in (push_src),
            .pop_in  (pop_src),
            .data    (cell_data[i])
        );
    end

    assign top    = cell_data[0];
    assign second = cell_data[1];

endmodule

### rtl/cursor_text_buffer_unit.sv
// Cursor text buffer: text held in two chains of byte cells split at the cursor.
// Insert, delete, step and ignored commands have their response registered in
// the cycle after acceptance; a jump to start or end answers on arrival. While
// the output is free, a jump moves one byte between the chains per cycle, and
// throughput is one command per cycle apart from jumps. Reset clears the counts,
// the controller and the response valid; the cell contents stay undefined.
`include "assert_macros.svh"

module cursor_text_buffer_unit #(
    parameter int DEPTH = ctb_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ctb_pkg::in_word_t  cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ctb_pkg::out_word_t rsp_word
);
    import ctb_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    state_t      state_reg, state_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] length_reg, length_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg, out_word_next;

    stack_ctl_t  left_ctl, right_ctl;
    logic [7:0]  left_top, left_second, right_top, right_second;
    logic [7:0]  left_top_next, right_top_next;
    logic        out_free, cmd_fire, finish;
    status_t     status;

    // Bytes before the cursor, nearest first.
    ctb_stack #(.DEPTH(DEPTH)) u_left (
        .clk    (clk),
        .ctl    (left_ctl),
        .top    (left_top),
        .second (left_second)
    );

    // Bytes after the cursor, nearest first.
    ctb_stack #(.DEPTH(DEPTH)) u_right (
        .clk    (clk),
        .ctl    (right_ctl),
        .top    (right_top),
        .second (right_second)
    );

    assign out_free  = !out_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign cmd_fire  = cmd_valid && cmd_ready;

    // Decode the command or continue a jump, and build the response word.
    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        length_next = length_reg;
        left_ctl    = '{op: OP_HOLD, din: 8'h00};
        right_ctl   = '{op: OP_HOLD, din: 8'h00};
        finish      = 1'b0;
        status      = STAT_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    finish = 1'b1;
                    unique case (cmd_word.cmd) inside
                        CMD_INSERT:
                        begin
                            if (length_reg == CW'(DEPTH))
                            begin
                                status = STAT_FULL;
                            end
                            else
                            begin
                                left_ctl    = '{op: OP_PUSH, din: cmd_word.char_in};
                                cursor_next = cursor_reg + 1'b1;
                                length_next = length_reg + 1'b1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (cursor_reg == length_reg)
                            begin
                                status = STAT_IGNORED;
                            end
                            else
                            begin
                                right_ctl   = '{op: OP_POP, din: 8'h00};
                                length_next = length_reg - 1'b1;
                            end
                        end
                        CMD_FORWARD, CMD_END:
                        begin
                            if (cursor_reg == length_reg)
                            begin
                                if (cmd_word.cmd == CMD_FORWARD)
                                begin
                                    status = STAT_IGNORED;
                                end
                            end
                            else
                            begin
                                left_ctl    = '{op: OP_PUSH, din: right_top};
                                right_ctl   = '{op: OP_POP, din: 8'h00};
                                cursor_next = cursor_reg + 1'b1;
                                if (cmd_word.cmd == CMD_END && cursor_next != length_reg)
                                begin
                                    finish     = 1'b0;
                                    state_next = S_TO_END;
                                end
                            end
                        end
                        CMD_BACKWARD, CMD_START:
                        begin
                            if (cursor_reg == '0)
                            begin
                                if (cmd_word.cmd == CMD_BACKWARD)
                                begin
                                    status = STAT_IGNORED;
                                end
                            end
                            else
                            begin
                                right_ctl   = '{op: OP_PUSH, din: left_top};
                                left_ctl    = '{op: OP_POP, din: 8'h00};
                                cursor_next = cursor_reg - 1'b1;
                                if (cmd_word.cmd == CMD_START && cursor_next != '0)
                                begin
                                    finish     = 1'b0;
                                    state_next = S_TO_START;
                                end
                            end
                        end
                        default:
                        begin
                            status = STAT_IGNORED;
                        end
                    endcase
                end
            end
            S_TO_START:
            begin
                if (out_free)
                begin
                    right_ctl   = '{op: OP_PUSH, din: left_top};
                    left_ctl    = '{op: OP_POP, din: 8'h00};
                    cursor_next = cursor_reg - 1'b1;
                    if (cursor_next == '0)
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_TO_END:
            begin
                if (out_free)
                begin
                    left_ctl    = '{op: OP_PUSH, din: right_top};
                    right_ctl   = '{op: OP_POP, din: 8'h00};
                    cursor_next = cursor_reg + 1'b1;
                    if (cursor_next == length_reg)
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Stack tops as they will be after this cycle's operation.
        case (left_ctl.op)
            OP_PUSH: left_top_next = left_ctl.din;
            OP_POP:  left_top_next = left_second;
            default: left_top_next = left_top;
        endcase
        case (right_ctl.op)
            OP_PUSH: right_top_next = right_ctl.din;
            OP_POP:  right_top_next = right_second;
            default: right_top_next = right_top;
        endcase

        out_word_next.cursor_pos  = 9'(cursor_next);
        out_word_next.text_length = 9'(length_next);
        out_word_next.char_before = (cursor_next != '0) ? left_top_next : 8'h00;
        out_word_next.char_after  = (cursor_next != length_next) ? right_top_next : 8'h00;
        out_word_next.status      = status;

        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    // The cursor never passes the end of the text.
    `CTB_ASSERT_SAME(a_cursor_in_text, 1'b1, cursor_reg <= length_reg)
    // The text never outgrows the cell chains.
    `CTB_ASSERT_SAME(a_length_bound, 1'b1, length_reg <= CW'(DEPTH))
    // A jump toward the start is only in progress while the cursor is off the start.
    `CTB_ASSERT_SAME(a_jump_start_live, state_reg == S_TO_START, cursor_reg != '0)
    // An accepted insert with room grows the text by exactly one byte.
    `CTB_ASSERT_NEXT(a_insert_grows,
        cmd_fire && cmd_word.cmd == CMD_INSERT && length_reg != CW'(DEPTH),
        length_reg == $past(length_reg) + 1'b1)

endmodule

### tb/sv/tb_cursor_text_buffer_unit.sv
// Self-checking testbench for cursor_text_buffer_unit: random commands with random gaps
// on both channels, checked against a behavioral model of the text and the cursor.
// Depends on ctb_pkg and the RTL of cursor_text_buffer_unit.
module tb_cursor_text_buffer_unit;

    import ctb_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    // Command codes that the block does not define.
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    in_word_t  cmd_word = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_word_t rsp_word;

    // Words waiting to be sent and responses waiting to arrive.
    in_word_t  pending_cmds[$];
    out_word_t expected_rsps[$];

    // Model of the text and the cursor.
    logic [7:0] text_mem [DEPTH];
    int         text_len = 0;
    int         cur_pos = 0;

    int mismatch_count = 0;
    int rsp_count = 0;
    int cmd_gap = 0;
    int cmd_quiet = 0;
    int rsp_stall = 0;
    int rsp_quiet = 0;

    cursor_text_buffer_unit #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Applies one command to the model and returns the response it must produce.
    task automatic predict_response(input in_word_t w, output out_word_t r);
        status_t st;
        int      i;
        st = STAT_OK;
        case (w.cmd)
            CMD_INSERT:
            begin
                if (text_len >= DEPTH)
                    st = STAT_FULL;
                else
                begin
                    for (i = text_len; i > cur_pos; i--)
                        text_mem[i] = text_mem[i - 1];
                    text_mem[cur_pos] = w.char_in;
                    cur_pos++;
                    text_len++;
                end
            end
            CMD_DELETE:
            begin
                if (cur_pos >= text_len)
                    st = STAT_IGNORED;
                else
                begin
                    for (i = cur_pos; i + 1 < text_len; i++)
                        text_mem[i] = text_mem[i + 1];
                    text_len--;
                end
            end
            CMD_FORWARD:
            begin
                if (cur_pos < text_len)
                    cur_pos++;
                else
                    st = STAT_IGNORED;
            end
            CMD_BACKWARD:
            begin
                if (cur_pos > 0)
                    cur_pos--;
                else
                    st = STAT_IGNORED;
            end
            CMD_START: cur_pos = 0;
            CMD_END:   cur_pos = text_len;
            default:   st = STAT_IGNORED;
        endcase
        r.cursor_pos  = 9'(cur_pos);
        r.text_length = 9'(text_len);
        r.char_before = (cur_pos > 0) ? text_mem[cur_pos - 1] : 8'h00;
        r.char_after  = (cur_pos < text_len) ? text_mem[cur_pos] : 8'h00;
        r.status      = st;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at response %0d: %s got %0h expected %0h",
                 rsp_count, what, got, want);
    endtask

    // Idle length: mostly none or short, a few long, and quiet runs with none at all.
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_cmd(input logic [2:0] code, input logic [7:0] ch);
        in_word_t w;
        w.cmd = code;
        w.char_in = ch;
        pending_cmds.push_back(w);
    endtask

    // Draws a command code from the given weights.
    function automatic logic [2:0] pick_cmd(input int w_ins, input int w_del, input int w_fwd,
                                            input int w_bwd, input int w_start, input int w_end,
                                            input int w_spare);
        int r;
        r = $urandom_range(0, w_ins + w_del + w_fwd + w_bwd + w_start + w_end + w_spare - 1);
        if (r < w_ins)
            return CMD_INSERT;
        r -= w_ins;
        if (r < w_del)
            return CMD_DELETE;
        r -= w_del;
        if (r < w_fwd)
            return CMD_FORWARD;
        r -= w_fwd;
        if (r < w_bwd)
            return CMD_BACKWARD;
        r -= w_bwd;
        if (r < w_start)
            return CMD_START;
        r -= w_start;
        if (r < w_end)
            return CMD_END;
        return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    // Command driver: the model is updated on each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_rsp;
        logic      holding;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_word  <= '0;
        end
        else
        begin
            holding = cmd_valid;
            if (cmd_valid && cmd_ready)
            begin
                predict_response(cmd_word, exp_rsp);
                expected_rsps.push_back(exp_rsp);
                cmd_gap = pick_gap(cmd_quiet);
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (cmd_gap > 0)
                begin
                    cmd_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_word  <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Response monitor: each accepted word is checked against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_count++;
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected response word",
                                    int'(rsp_word.cursor_pos), 0);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_word.cursor_pos !== want.cursor_pos)
                        report_mismatch("cursor_pos", int'(rsp_word.cursor_pos),
                                        int'(want.cursor_pos));
                    if (rsp_word.text_length !== want.text_length)
                        report_mismatch("text_length", int'(rsp_word.text_length),
                                        int'(want.text_length));
                    if (rsp_word.char_before !== want.char_before)
                        report_mismatch("char_before", int'(rsp_word.char_before),
                                        int'(want.char_before));
                    if (rsp_word.char_after !== want.char_after)
                        report_mismatch("char_after", int'(rsp_word.char_after),
                                        int'(want.char_after));
                    if (rsp_word.status !== want.status)
                        report_mismatch("status", int'(rsp_word.status),
                                        int'(want.status));
                end
                rsp_stall = pick_gap(rsp_quiet);
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int inserts;
        int i;
        logic [2:0] code;

        // Directed: boundaries on the empty text, spare codes, edits in the middle,
        // and deleting back down to empty.
        push_cmd(CMD_BACKWARD, 8'h11);
        push_cmd(CMD_DELETE, 8'h22);
        push_cmd(CMD_FORWARD, 8'h33);
        push_cmd(CMD_START, 8'h00);
        push_cmd(CMD_END, 8'hFF);
        push_cmd(CMD_SPARE_LO, 8'h44);
        push_cmd(CMD_SPARE_HI, 8'h55);
        push_cmd(CMD_INSERT, 8'h00);
        push_cmd(CMD_INSERT, 8'hFF);
        push_cmd(CMD_INSERT, 8'hA5);
        push_cmd(CMD_BACKWARD, 8'h00);
        push_cmd(CMD_BACKWARD, 8'h00);
        push_cmd(CMD_INSERT, 8'h5A);
        push_cmd(CMD_DELETE, 8'h00);
        push_cmd(CMD_START, 8'h00);
        push_cmd(CMD_BACKWARD, 8'h00);
        push_cmd(CMD_FORWARD, 8'h00);
        push_cmd(CMD_END, 8'h00);
        push_cmd(CMD_DELETE, 8'h00);
        push_cmd(CMD_FORWARD, 8'h00);
        push_cmd(CMD_END, 8'h00);
        push_cmd(CMD_START, 8'h00);
        push_cmd(CMD_DELETE, 8'h00);
        push_cmd(CMD_DELETE, 8'h00);
        push_cmd(CMD_DELETE, 8'h00);

        // Noise: every code, including the spare ones, at even odds.
        for (i = 0; i < 40; i++)
            push_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));

        // Fill: no deletes, so the text is full within DEPTH inserts;
        // at least the last 8 inserts must be dropped.
        inserts = 0;
        while (inserts < DEPTH + 8)
        begin
            code = pick_cmd(80, 0, 5, 7, 3, 3, 2);
            if (code == CMD_INSERT)
                inserts++;
            push_cmd(code, 8'($urandom_range(0, 255)));
        end

        // Drain: mostly deletes, with jumps and steps to move the cursor off the end.
        push_cmd(CMD_START, 8'h00);
        for (i = 0; i < 200; i++)
            push_cmd(pick_cmd(5, 70, 6, 6, 8, 3, 2), 8'($urandom_range(0, 255)));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (mismatch_count == 0)
            $display("** cursor_text_buffer_unit: PASSED **");
        else
            $display("** cursor_text_buffer_unit: FAILED **");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #12000000;
        $display("** cursor_text_buffer_unit: FAILED **");
        $finish;
    end

endmodule
